// ----- design/edd_pkg.sv -----
`timescale 1ns / 1ps

package edd_pkg;

    // Geometry
    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CNT_W       = COL_W + 1;
    localparam int ROW_WIDTH_W = 12;
    localparam int WCMP_W      = (CNT_W > ROW_WIDTH_W) ? CNT_W : ROW_WIDTH_W;

    // Color lanes: red, green, blue
    localparam int NUM_LANES   = 3;
    localparam int ERR_W       = 9;
    localparam int ROW_WORD_W  = NUM_LANES * ERR_W;

    // Quantizer reciprocal: ceil(2^24 / n)
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // APB register map
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam logic [1:0] REG_LEVEL_BITS = 2'd0;
    localparam logic [1:0] REG_MONO_MODE  = 2'd1;
    localparam logic [1:0] REG_CHAN_EN    = 2'd2;
    localparam logic [1:0] REG_ROW_WIDTH  = 2'd3;

    typedef logic signed [ERR_W-1:0] t_err;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
    } t_pix_out;

    // Error shares of one lane: right, down, down-left, down-right
    typedef struct packed {
        t_err t7;
        t_err t5;
        t_err t3;
        t_err t1;
    } t_spread;

    // Stage loads of the lane datapath
    typedef struct packed {
        logic adj_en;
        logic mul_en;
        logic kq_en;
        logic div_en;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADJ,
        S_MUL,
        S_KQ,
        S_DIV,
        S_ERR,
        S_LAST,
        S_OUT
    } t_state;

    // Clamp level_bits to 1..8
    function automatic logic [3:0] f_eff_bits(input logic [3:0] bits);
        logic [3:0] b;
        b = bits;
        if (b == 4'd0) begin
            b = 4'd1;
        end else if (b > 4'd8) begin
            b = 4'd8;
        end
        return b;
    endfunction

    // Highest level index, 2^bits - 1
    function automatic logic [7:0] f_levels(input logic [3:0] bits);
        logic [8:0] p;
        p = 9'd1 << f_eff_bits(bits);
        return 8'(p - 9'd1);
    endfunction

    function automatic logic [RECIP_W-1:0] f_recip(input logic [3:0] bits);
        logic [RECIP_W-1:0] r;
        case (f_eff_bits(bits))
            4'd1:    r = RECIP_W'(16777216);
            4'd2:    r = RECIP_W'(5592406);
            4'd3:    r = RECIP_W'(2396746);
            4'd4:    r = RECIP_W'(1118482);
            4'd5:    r = RECIP_W'(541201);
            4'd6:    r = RECIP_W'(266306);
            4'd7:    r = RECIP_W'(132105);
            default: r = RECIP_W'(65794);
        endcase
        return r;
    endfunction

endpackage

// ----- design/edd_lane.sv -----
`timescale 1ns / 1ps

// One color channel: error-adjusted sample, quantizer, error shares.
module edd_lane import edd_pkg::*; (
    input  logic               i_clk,
    input  t_lane_ctl          i_ctl,
    input  logic               i_en,
    input  logic [7:0]         i_pix,
    input  t_err               i_right,
    input  t_err               i_row,
    input  logic [7:0]         i_levels,
    input  logic [RECIP_W-1:0] i_recip,
    output logic [7:0]         o_res,
    output t_spread            o_spread
);

    logic [7:0]  r_adj;
    logic [15:0] r_prod;
    logic [15:0] r_mq;
    logic [7:0]  r_q;

    logic [10:0] sum;
    logic [7:0]  n_adj;
    logic [15:0] x;
    logic [15:0] kx;
    logic [7:0]  k;
    logic [15:0] n_mq;
    logic [40:0] div_prod;
    t_err        err;
    logic signed [11:0] e12;
    logic signed [11:0] p7;
    logic signed [11:0] p5;
    logic signed [11:0] p3;

    // sample + right error + row error, clamped to 0..255
    always_comb begin
        sum = {3'b000, i_pix}
            + {{2{i_right[ERR_W-1]}}, i_right}
            + {{2{i_row[ERR_W-1]}}, i_row};
        if (sum[10]) begin
            n_adj = 8'd0;
        end else if (sum[9:8] != 2'b00) begin
            n_adj = 8'd255;
        end else begin
            n_adj = sum[7:0];
        end
    end

    // k = floor((v*n + 127) / 255), then m = 255*k + n/2
    always_comb begin
        x    = r_prod + 16'd127;
        kx   = x + {8'd0, x[15:8]} + 16'd1;
        k    = kx[15:8];
        n_mq = {k, 8'd0} - {8'd0, k} + {9'd0, i_levels[7:1]};
    end

    assign div_prod = {25'd0, r_mq} * {16'd0, i_recip};

    always_ff @(posedge i_clk) begin
        if (i_ctl.adj_en) begin
            r_adj <= n_adj;
        end
        if (i_ctl.mul_en) begin
            r_prod <= {8'd0, r_adj} * {8'd0, i_levels};
        end
        if (i_ctl.kq_en) begin
            r_mq <= n_mq;
        end
        if (i_ctl.div_en) begin
            r_q <= div_prod[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    end

    always_comb begin
        if (i_en) begin
            o_res = r_q;
            err   = t_err'({1'b0, r_adj} - {1'b0, r_q});
        end else begin
            o_res = i_pix;
            err   = '0;
        end
        e12 = 12'(err);
        p7  = (e12 <<< 3) - e12;
        p5  = (e12 <<< 2) + e12;
        p3  = (e12 <<< 1) + e12;
        o_spread.t7 = t_err'(p7 >>> 4);
        o_spread.t5 = t_err'(p5 >>> 4);
        o_spread.t3 = t_err'(p3 >>> 4);
        o_spread.t1 = t_err'(err >>> 4);
    end

endmodule

// ----- design/edd_merge.sv -----
`timescale 1ns / 1ps

// Combines lane results into one pixel (grey in mono mode) and holds it
// in the output register.
module edd_merge import edd_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_mono,
    input  logic [NUM_LANES-1:0][7:0]   i_res,
    input  logic                        i_out_ready,
    output logic                        o_free,
    output logic                        o_out_valid,
    output t_pix_out                    o_out_data
);

    logic     r_valid;
    t_pix_out r_data;
    t_pix_out n_data;

    always_comb begin
        if (i_mono) begin
            n_data.out_red   = i_res[0];
            n_data.out_green = i_res[0];
            n_data.out_blue  = i_res[0];
        end else begin
            n_data.out_red   = i_res[0];
            n_data.out_green = i_res[1];
            n_data.out_blue  = i_res[2];
        end
    end

    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// ----- design/error_diffusion_dither.sv -----
`timescale 1ns / 1ps

// Error diffusion dither for an RGB pixel stream in raster order (7/16 right,
// 3/16 down-left, 5/16 down, 1/16 down-right).
// Input transaction: i_in_valid / o_in_ready with t_pix_in (three 8-bit samples
// and frame_start). Output transaction: o_out_valid / i_out_ready with t_pix_out.
// Registers (level_bits, mono_mode, channel_enable, row_width) sit on an APB
// port at 0x0, 0x4, 0x8, 0xC; write them only while no pixel is in flight.
// One pixel is worked at a time, one stage per cycle through the lane
// datapath (adjust, multiply, level index, reciprocal multiply, error
// spread). The next pixel is accepted once the previous one leaves the
// output state; the last pixel of a row takes an extra state for a second
// write on the row error RAM. S_OUT loads the result onto o_out_valid.
// The output register decouples the two sides: the next pixel is accepted
// while the previous result still waits; a stalled receiver holds the result
// and the pipeline parks in its output state until the register frees up.
// Reset restores register defaults and clears all carried errors. The row
// error RAM is never swept: a fill count of columns written in the current
// frame marks which entries are live, the rest read as zero. frame_start
// clears carried errors and the fill count before its pixel is processed.
module error_diffusion_dither import edd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel in
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_pix_in           i_in_data,
    // pixel out
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_pix_out          o_out_data,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [3:0]             r_level_bits;
    logic                   r_mono;
    logic [NUM_LANES-1:0]   r_chan_en;
    logic [ROW_WIDTH_W-1:0] r_row_width;
    logic [1:0]             reg_idx;
    logic                   cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_bits <= 4'd1;
            r_mono       <= 1'b0;
            r_chan_en    <= '1;
            r_row_width  <= ROW_WIDTH_W'(2048);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LEVEL_BITS: r_level_bits <= pwdata[3:0];
                REG_MONO_MODE:  r_mono       <= pwdata[0];
                REG_CHAN_EN:    r_chan_en    <= pwdata[NUM_LANES-1:0];
                REG_ROW_WIDTH:  r_row_width  <= pwdata[ROW_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LEVEL_BITS: prdata = {28'd0, r_level_bits};
            REG_MONO_MODE:  prdata = {31'd0, r_mono};
            REG_CHAN_EN:    prdata = {{(DATA_W-NUM_LANES){1'b0}}, r_chan_en};
            REG_ROW_WIDTH:  prdata = {{(DATA_W-ROW_WIDTH_W){1'b0}}, r_row_width};
            default:        prdata = '0;
        endcase
    end

    // Quantizer constants follow level_bits
    logic [7:0]         levels;
    logic [RECIP_W-1:0] recip;

    assign levels = f_levels(r_level_bits);
    assign recip  = f_recip(r_level_bits);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic [COL_W-1:0] r_col;     // column of the next pixel
    logic [CNT_W-1:0] r_fill;    // columns of the row RAM written this frame
    logic [COL_W-1:0] r_c;       // column of the pixel in flight
    logic             r_last;
    logic             r_rd_ok;

    logic             in_acc;
    logic             out_free;
    logic             out_load;
    t_lane_ctl        lane_ctl;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Effective row width, clamped to 1..MAX_WIDTH
    logic [WCMP_W-1:0] rw_ext;
    logic [CNT_W-1:0]  eff_w;
    logic [COL_W-1:0]  col_eff;
    logic [COL_W-1:0]  c_sel;
    logic              last_sel;
    logic [CNT_W-1:0]  w_m1;

    always_comb begin
        rw_ext = WCMP_W'(r_row_width);
        if (rw_ext == '0) begin
            eff_w = CNT_W'(1);
        end else if (rw_ext > WCMP_W'(MAX_WIDTH)) begin
            eff_w = CNT_W'(MAX_WIDTH);
        end else begin
            eff_w = CNT_W'(rw_ext);
        end
        w_m1    = eff_w - CNT_W'(1);
        col_eff = i_in_data.frame_start ? '0 : r_col;
        // width shrank mid-row: treat as last column
        if (CNT_W'(col_eff) >= eff_w) begin
            c_sel = w_m1[COL_W-1:0];
        end else begin
            c_sel = col_eff;
        end
        last_sel = (CNT_W'(c_sel) == w_m1);
    end

    // Mono mode works on HSL lightness (max + min) / 2
    logic [7:0] mx_rg;
    logic [7:0] mn_rg;
    logic [7:0] mx;
    logic [7:0] mn;
    logic [8:0] light_sum;

    always_comb begin
        mx_rg = (i_in_data.in_green > i_in_data.in_red) ? i_in_data.in_green
                                                        : i_in_data.in_red;
        mn_rg = (i_in_data.in_green < i_in_data.in_red) ? i_in_data.in_green
                                                        : i_in_data.in_red;
        mx = (i_in_data.in_blue > mx_rg) ? i_in_data.in_blue : mx_rg;
        mn = (i_in_data.in_blue < mn_rg) ? i_in_data.in_blue : mn_rg;
        light_sum = {1'b0, mx} + {1'b0, mn};
    end

    // ---------------------------------------------------------------
    // FSM: one pixel through the lane stages
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        lane_ctl = '0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_ADJ;
                end
            end
            S_ADJ: begin
                lane_ctl.adj_en = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                lane_ctl.mul_en = 1'b1;
                n_state = S_KQ;
            end
            S_KQ: begin
                lane_ctl.kq_en = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                lane_ctl.div_en = 1'b1;
                n_state = S_ERR;
            end
            S_ERR: begin
                n_state = r_last ? S_LAST : S_OUT;
            end
            S_LAST: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Row error RAM: read at accept, write c-1 in S_ERR, c in S_LAST
    // ---------------------------------------------------------------
    logic [ROW_WORD_W-1:0] r_row_mem [MAX_WIDTH];
    logic [ROW_WORD_W-1:0] r_row_rd;
    logic [ROW_WORD_W-1:0] r_word_c;
    logic [ROW_WORD_W-1:0] word_cm1;
    logic [ROW_WORD_W-1:0] word_c;
    logic                  mem_we;
    logic [COL_W-1:0]      mem_wa;
    logic [ROW_WORD_W-1:0] mem_wd;

    always_comb begin
        mem_we = ((r_state == S_ERR) && (r_c != '0)) || (r_state == S_LAST);
        mem_wa = (r_state == S_LAST) ? r_c : r_c - COL_W'(1);
        mem_wd = (r_state == S_LAST) ? r_word_c : word_cm1;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_row_mem[mem_wa] <= mem_wd;
        end
        if (in_acc) begin
            r_row_rd <= r_row_mem[c_sel];
        end
    end

    // ---------------------------------------------------------------
    // Pixel and carried errors
    // ---------------------------------------------------------------
    logic [NUM_LANES-1:0][7:0] r_pix;
    t_err                      r_right [NUM_LANES];
    t_err                      r_pend0 [NUM_LANES];
    t_err                      r_pend1 [NUM_LANES];

    t_err                      row_err [NUM_LANES];
    logic [NUM_LANES-1:0]      lane_en;
    logic [NUM_LANES-1:0][7:0] lane_res;
    t_spread                   lane_sp [NUM_LANES];
    logic [CNT_W-1:0]          fill_cand;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix[0] <= r_mono ? light_sum[8:1] : i_in_data.in_red;
            r_pix[1] <= i_in_data.in_green;
            r_pix[2] <= i_in_data.in_blue;
        end
        if (r_state == S_ERR) begin
            r_word_c <= word_c;
        end
    end

    // entries at or past the fill count were not written this frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_fill  <= '0;
            r_c     <= '0;
            r_last  <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            if (in_acc) begin
                r_c     <= c_sel;
                r_last  <= last_sel;
                r_rd_ok <= !i_in_data.frame_start && (CNT_W'(c_sel) < r_fill);
                if (i_in_data.frame_start) begin
                    r_fill <= '0;
                end
            end
            if (r_state == S_ERR) begin
                r_col <= r_last ? '0 : r_c + COL_W'(1);
                if (fill_cand > r_fill) begin
                    r_fill <= fill_cand;
                end
            end
        end
    end

    assign fill_cand = r_last ? CNT_W'(r_c) + CNT_W'(1) : CNT_W'(r_c);

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++) begin : g_lane
            assign row_err[g] = r_rd_ok ? t_err'(r_row_rd[g*ERR_W +: ERR_W]) : '0;
            assign lane_en[g] = r_mono ? (g == 0) : r_chan_en[g];

            // down-left share lands on c-1, down share on c
            assign word_cm1[g*ERR_W +: ERR_W] = t_err'(r_pend0[g] + lane_sp[g].t3);
            assign word_c[g*ERR_W +: ERR_W]   = t_err'(r_pend1[g] + lane_sp[g].t5);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_right[g] <= '0;
                    r_pend0[g] <= '0;
                    r_pend1[g] <= '0;
                end else if (in_acc && i_in_data.frame_start) begin
                    r_right[g] <= '0;
                    r_pend0[g] <= '0;
                    r_pend1[g] <= '0;
                end else if (r_state == S_ERR) begin
                    if (r_last) begin
                        r_right[g] <= '0;
                        r_pend0[g] <= '0;
                        r_pend1[g] <= '0;
                    end else begin
                        r_right[g] <= lane_sp[g].t7;
                        r_pend0[g] <= word_c[g*ERR_W +: ERR_W];
                        r_pend1[g] <= lane_sp[g].t1;
                    end
                end
            end

            edd_lane u_lane (
                .i_clk    (i_clk),
                .i_ctl    (lane_ctl),
                .i_en     (lane_en[g]),
                .i_pix    (r_pix[g]),
                .i_right  (r_right[g]),
                .i_row    (row_err[g]),
                .i_levels (levels),
                .i_recip  (recip),
                .o_res    (lane_res[g]),
                .o_spread (lane_sp[g])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Merge and output register
    // ---------------------------------------------------------------
    edd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (out_load),
        .i_mono      (r_mono),
        .i_res       (lane_res),
        .i_out_ready (i_out_ready),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
